/* sv/csm_pkg.sv */
// ----------------------------------------------------------------------------
// csm_pkg
// Shared constants and types of the compressed-sparse-row matrix store.
// ----------------------------------------------------------------------------
package csm_pkg;

  localparam int unsigned MaxRows    = 256;
  localparam int unsigned MaxColumns = 256;
  localparam int unsigned MaxEntries = 1024;

  localparam int unsigned IndexW  = 8;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountW  = 9;
  localparam int unsigned StatusW = 2;

  typedef enum logic [StatusW-1:0] {
    StatusOk    = 2'd0,
    StatusRange = 2'd1,
    StatusFull  = 2'd2,
    StatusSat   = 2'd3
  } status_e;

  typedef enum logic {
    CfgRowCount    = 1'b0,
    CfgColumnCount = 1'b1
  } cfg_index_e;

  typedef enum logic [3:0] {
    StateClear,
    StateIdle,
    StateRowStart,
    StateRowEnd,
    StateTotal,
    StateScanRead,
    StateScanCompare,
    StateDecide,
    StateShift,
    StateInsert,
    StateIncrement
  } state_e;

endpackage

/* sv/csm_ram.sv */
// ----------------------------------------------------------------------------
// csm_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module csm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/csr_sparse_matrix_store_core.sv */
// ----------------------------------------------------------------------------
// csr_sparse_matrix_store_core
// Sparse matrix store in compressed-sparse-row form with add and read items.
// ----------------------------------------------------------------------------
// An out-of-range item returns its result in the cycle after start. A read or
// accumulate reads the row's start and end offsets and the entry total, then scans
// the row's entries by column; an insert then shifts the later entries up, writes
// the new entry and increments the row offsets above the row. One item at a time.
// The result strobe cannot be stalled.
// After reset a clearing pass zeroes all MaxRows + 1 row offsets and keeps busy high.
module csr_sparse_matrix_store_core
  import csm_pkg::*;
#(
  parameter int unsigned MaxRowsP    = csm_pkg::MaxRows,
  parameter int unsigned MaxColumnsP = csm_pkg::MaxColumns,
  parameter int unsigned MaxEntriesP = csm_pkg::MaxEntries
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     mode_i,
  input  logic [IndexW-1:0]        row_i,
  input  logic [IndexW-1:0]        column_i,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     done_o,
  output logic signed [ValueW-1:0] read_value_o,
  output logic [StatusW-1:0]       status_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_index_i,
  input  logic [CountW-1:0]        cfg_wdata_i
);

  localparam int unsigned RsAw  = $clog2(MaxRowsP + 1);
  localparam int unsigned RsCw  = $clog2(MaxRowsP + 2);
  localparam int unsigned RsW   = $clog2(MaxEntriesP + 1);
  localparam int unsigned EntAw = (MaxEntriesP > 1) ? $clog2(MaxEntriesP) : 1;
  localparam int unsigned EntW  = IndexW + ValueW;

  state_e state_q, state_d;

  logic [CountW-1:0]        row_count_q, column_count_q;
  logic                     mode_q, mode_d;
  logic [IndexW-1:0]        row_q, row_d, col_q, col_d;
  logic signed [ValueW-1:0] value_q, value_d;
  logic [RsW-1:0]           start_q, start_d, end_q, end_d, total_q, total_d;
  logic [RsW-1:0]           p_q, p_d;
  logic                     found_q, found_d;
  logic signed [ValueW-1:0] ent_val_q, ent_val_d;
  logic [EntAw-1:0]         sh_q, sh_d, ent_wa_q, ent_wa_d;
  logic [RsAw-1:0]          rs_wa_q, rs_wa_d;
  logic [RsCw-1:0]          r_q, r_d, clr_q, clr_d;
  logic                     have_q, have_d, last_q, last_d;
  logic                     done_q, done_d;
  logic signed [ValueW-1:0] res_val_q, res_val_d;
  status_e                  res_status_q, res_status_d;

  logic             rs_we;
  logic [RsAw-1:0]  rs_waddr, rs_raddr;
  logic [RsW-1:0]   rs_wdata, rs_rdata;
  logic             ent_we;
  logic [EntAw-1:0] ent_waddr, ent_raddr;
  logic [EntW-1:0]  ent_wdata, ent_rdata;

  logic                     in_range;
  logic [IndexW-1:0]        ent_col;
  logic [ValueW:0]          sum;
  logic                     sum_ovf;
  logic signed [ValueW-1:0] sum_sat;

  csm_ram #(.Width(RsW), .Depth(MaxRowsP + 1), .AddrW(RsAw)) u_row_start_ram (
    .clk_i  (clk_i),
    .we_i   (rs_we),
    .waddr_i(rs_waddr),
    .wdata_i(rs_wdata),
    .raddr_i(rs_raddr),
    .rdata_o(rs_rdata)
  );

  csm_ram #(.Width(EntW), .Depth(MaxEntriesP), .AddrW(EntAw)) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(ent_waddr),
    .wdata_i(ent_wdata),
    .raddr_i(ent_raddr),
    .rdata_o(ent_rdata)
  );

  assign in_range = ({1'b0, row_i} < row_count_q) && (32'(row_i) < MaxRowsP) &&
                    ({1'b0, column_i} < column_count_q) && (32'(column_i) < MaxColumnsP);
  assign ent_col  = ent_rdata[EntW-1:ValueW];
  assign sum      = {ent_val_q[ValueW-1], ent_val_q} + {value_q[ValueW-1], value_q};
  assign sum_ovf  = sum[ValueW] != sum[ValueW-1];
  assign sum_sat  = !sum_ovf ? $signed(sum[ValueW-1:0]) :
                    sum[ValueW] ? $signed({1'b1, {(ValueW-1){1'b0}}}) :
                                  $signed({1'b0, {(ValueW-1){1'b1}}});

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    row_d        = row_q;
    col_d        = col_q;
    value_d      = value_q;
    start_d      = start_q;
    end_d        = end_q;
    total_d      = total_q;
    p_d          = p_q;
    found_d      = found_q;
    ent_val_d    = ent_val_q;
    sh_d         = sh_q;
    ent_wa_d     = ent_wa_q;
    rs_wa_d      = rs_wa_q;
    r_d          = r_q;
    clr_d        = clr_q;
    have_d       = have_q;
    last_d       = last_q;
    done_d       = 1'b0;
    res_val_d    = res_val_q;
    res_status_d = res_status_q;
    rs_we        = 1'b0;
    rs_waddr     = rs_wa_q;
    rs_wdata     = rs_rdata + RsW'(1);
    rs_raddr     = RsAw'(row_i);
    ent_we       = 1'b0;
    ent_waddr    = ent_wa_q;
    ent_wdata    = ent_rdata;
    ent_raddr    = p_q[EntAw-1:0];

    case (state_q)
      StateClear: begin
        rs_we    = 1'b1;
        rs_waddr = clr_q[RsAw-1:0];
        rs_wdata = '0;
        clr_d    = clr_q + RsCw'(1);
        if (32'(clr_q) == MaxRowsP) begin
          state_d = StateIdle;
        end
      end
      StateIdle: begin
        if (start_i) begin
          mode_d  = mode_i;
          row_d   = row_i;
          col_d   = column_i;
          value_d = value_i;
          if (in_range) begin
            state_d = StateRowStart;
          end else begin
            done_d       = 1'b1;
            res_val_d    = '0;
            res_status_d = StatusRange;
          end
        end
      end
      StateRowStart: begin
        start_d  = rs_rdata;
        rs_raddr = RsAw'({1'b0, row_q} + 9'd1);
        state_d  = StateRowEnd;
      end
      StateRowEnd: begin
        end_d    = rs_rdata;
        rs_raddr = RsAw'(MaxRowsP);
        state_d  = StateTotal;
      end
      StateTotal: begin
        total_d = rs_rdata;
        end_d   = (end_q > rs_rdata) ? rs_rdata : end_q;
        p_d     = start_q;
        state_d = StateScanRead;
      end
      StateScanRead: begin
        if (p_q < end_q) begin
          state_d = StateScanCompare;
        end else begin
          found_d = 1'b0;
          state_d = StateDecide;
        end
      end
      StateScanCompare: begin
        if (ent_col < col_q) begin
          p_d     = p_q + RsW'(1);
          state_d = StateScanRead;
        end else begin
          found_d   = ent_col == col_q;
          ent_val_d = $signed(ent_rdata[ValueW-1:0]);
          state_d   = StateDecide;
        end
      end
      StateDecide: begin
        if (mode_q || value_q == '0) begin
          done_d       = 1'b1;
          res_val_d    = found_q ? ent_val_q : '0;
          res_status_d = StatusOk;
          state_d      = StateIdle;
        end else if (found_q) begin
          ent_we       = 1'b1;
          ent_waddr    = p_q[EntAw-1:0];
          ent_wdata    = {col_q, sum_sat};
          done_d       = 1'b1;
          res_val_d    = sum_sat;
          res_status_d = sum_ovf ? StatusSat : StatusOk;
          state_d      = StateIdle;
        end else if (32'(total_q) >= MaxEntriesP) begin
          done_d       = 1'b1;
          res_val_d    = '0;
          res_status_d = StatusFull;
          state_d      = StateIdle;
        end else if (total_q > p_q) begin
          sh_d    = EntAw'(total_q - RsW'(1));
          have_d  = 1'b0;
          state_d = StateShift;
        end else begin
          state_d = StateInsert;
        end
      end
      StateShift: begin
        ent_raddr = sh_q;
        ent_wa_d  = sh_q + EntAw'(1);
        last_d    = sh_q == p_q[EntAw-1:0];
        sh_d      = sh_q - EntAw'(1);
        have_d    = 1'b1;
        if (have_q) begin
          ent_we = 1'b1;
          if (last_q) begin
            state_d = StateInsert;
          end
        end
      end
      StateInsert: begin
        ent_we    = 1'b1;
        ent_waddr = p_q[EntAw-1:0];
        ent_wdata = {col_q, value_q};
        r_d       = RsCw'(row_q) + RsCw'(1);
        have_d    = 1'b0;
        state_d   = StateIncrement;
      end
      StateIncrement: begin
        rs_raddr = r_q[RsAw-1:0];
        rs_wa_d  = r_q[RsAw-1:0];
        last_d   = 32'(r_q) == MaxRowsP;
        r_d      = r_q + RsCw'(1);
        have_d   = 1'b1;
        if (have_q) begin
          rs_we = 1'b1;
          if (last_q) begin
            done_d       = 1'b1;
            res_val_d    = value_q;
            res_status_d = StatusOk;
            state_d      = StateIdle;
          end
        end
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StateClear;
      row_count_q    <= CountW'(256);
      column_count_q <= CountW'(256);
      mode_q         <= 1'b0;
      row_q          <= '0;
      col_q          <= '0;
      value_q        <= '0;
      start_q        <= '0;
      end_q          <= '0;
      total_q        <= '0;
      p_q            <= '0;
      found_q        <= 1'b0;
      ent_val_q      <= '0;
      sh_q           <= '0;
      ent_wa_q       <= '0;
      rs_wa_q        <= '0;
      r_q            <= '0;
      clr_q          <= '0;
      have_q         <= 1'b0;
      last_q         <= 1'b0;
      done_q         <= 1'b0;
      res_val_q      <= '0;
      res_status_q   <= StatusOk;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      row_q        <= row_d;
      col_q        <= col_d;
      value_q      <= value_d;
      start_q      <= start_d;
      end_q        <= end_d;
      total_q      <= total_d;
      p_q          <= p_d;
      found_q      <= found_d;
      ent_val_q    <= ent_val_d;
      sh_q         <= sh_d;
      ent_wa_q     <= ent_wa_d;
      rs_wa_q      <= rs_wa_d;
      r_q          <= r_d;
      clr_q        <= clr_d;
      have_q       <= have_d;
      last_q       <= last_d;
      done_q       <= done_d;
      res_val_q    <= res_val_d;
      res_status_q <= res_status_d;
      if (cfg_valid_i) begin
        case (cfg_index_e'(cfg_index_i))
          CfgRowCount:    row_count_q    <= cfg_wdata_i;
          CfgColumnCount: column_count_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  assign busy_o       = state_q != StateIdle;
  assign done_o       = done_q;
  assign read_value_o = res_val_q;
  assign status_o     = res_status_q;
  assign cfg_ready_o  = 1'b1;

  // The stored entry count read from the last row offset never exceeds capacity.
  a_total_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StateTotal |-> 32'(rs_rdata) <= MaxEntriesP)
    else $error("entry count exceeds capacity");

  // A saturated accumulate returns one of the two clamp values.
  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == StatusSat |->
      read_value_o == $signed(32'h7fffffff) || read_value_o == $signed(32'h80000000))
    else $error("saturated result is not clamped");

  // Range and full results carry a zero value.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == StatusRange || status_o == StatusFull) |-> read_value_o == '0)
    else $error("failed item returned a nonzero value");

  // The shift only moves entries at or above the insertion point.
  a_shift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StateShift && have_q |-> 32'(ent_wa_q) > 32'(p_q))
    else $error("entry shift below insertion point");

endmodule

/* tb/csr_sparse_matrix_store_core_tb.sv */
// ----------------------------------------------------------------------------
// csr_sparse_matrix_store_core_tb
// Self-checking bench for the compressed-sparse-row matrix store. A directed
// table covers empty reads, inserts at both ends of a row, saturation in both
// directions, zero addends, accumulation to zero and out-of-range indexes.
// Random add and read traffic then runs under several row and column counts,
// the store is filled to capacity, and traffic continues against the full
// store. Every result is compared with a behavioral model of the matrix kept
// in the bench, or with the table's value and status where the table gives them.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_store_core_tb;
  import csm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ModeAdd  = 1'b0;
  localparam logic ModeRead = 1'b1;
  localparam longint ValueMax = 64'sd2147483647;
  localparam longint ValueMin = -64'sd2147483648;
  localparam int NumSteps  = 31;
  localparam int NumPhases = 7;

  typedef enum logic {
    StepItem,
    StepWrite
  } step_kind_e;

  typedef struct packed {
    step_kind_e         kind;
    logic               mode;
    logic [IndexW-1:0]  row;
    logic [IndexW-1:0]  column;
    logic [ValueW-1:0]  value;
    logic               known;
    logic [ValueW-1:0]  want_value;
    status_e            want_status;
    cfg_index_e         reg_index;
    logic [CountW-1:0]  reg_data;
  } step_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    status_e                  status;
  } matrix_answer_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic                     busy_o;
  logic                     mode_i = ModeAdd;
  logic [IndexW-1:0]        row_i = '0;
  logic [IndexW-1:0]        column_i = '0;
  logic signed [ValueW-1:0] value_i = '0;
  logic                     done_o;
  logic signed [ValueW-1:0] read_value_o;
  logic [StatusW-1:0]       status_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic                     cfg_index_i = CfgRowCount;
  logic [CountW-1:0]        cfg_wdata_i = '0;

  logic                     table_known = 1'b0;
  logic [ValueW-1:0]        table_value = '0;
  status_e                  table_status = StatusOk;

  logic [10:0]              row_start [MaxRows+1];
  logic [IndexW-1:0]        entry_column [MaxEntries];
  logic signed [ValueW-1:0] entry_value [MaxEntries];
  logic [CountW-1:0]        rows_in_use = 9'd256;
  logic [CountW-1:0]        columns_in_use = 9'd256;

  matrix_answer_t pending_answers [$];
  int unsigned    mismatch_count = 0;

  step_t plan [NumSteps] = '{
    '{StepItem, ModeRead, 8'd0, 8'd0, 32'h0, 1'b1, 32'h0, StatusOk, CfgRowCount, 9'd0},
    '{StepItem, ModeRead, 8'd255, 8'd255, 32'h0, 1'b1, 32'h0, StatusOk, CfgRowCount, 9'd0},
    '{StepItem, ModeAdd, 8'd0, 8'd0, 32'h0, 1'b1, 32'h0, StatusOk, CfgRowCount, 9'd0},
    '{StepItem, ModeAdd, 8'd0, 8'd5, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF, StatusOk,
      CfgRowCount, 9'd0},
    '{StepItem, ModeAdd, 8'd0, 8'd5, 32'h1, 1'b1, 32'h7FFFFFFF, StatusSat, CfgRowCount, 9'd0},
    '{StepItem, ModeAdd, 8'd0, 8'd2, 32'h80000000, 1'b1, 32'h80000000, StatusOk,
      CfgRowCount, 9'd0},
    '{StepItem, ModeAdd, 8'd0, 8'd2, 32'hFFFFFFFF, 1'b1, 32'h80000000, StatusSat,
      CfgRowCount, 9'd0},
    '{StepItem, ModeAdd, 8'd0, 8'd9, 32'h00010000, 1'b1, 32'h00010000, StatusOk,
      CfgRowCount, 9'd0},
    '{StepItem, ModeAdd, 8'd0, 8'd9, 32'hFFFF0000, 1'b1, 32'h0, StatusOk, CfgRowCount, 9'd0},
    '{StepItem, ModeRead, 8'd0, 8'd9, 32'h0, 1'b0, 32'h0, StatusOk, CfgRowCount, 9'd0},
    '{StepItem, ModeAdd, 8'd0, 8'd9, 32'h0, 1'b0, 32'h0, StatusOk, CfgRowCount, 9'd0},
    '{StepItem, ModeAdd, 8'd255, 8'd255, 32'hA5A5A5A5, 1'b0, 32'h0, StatusOk, CfgRowCount, 9'd0},
    '{StepItem, ModeAdd, 8'd255, 8'd0, 32'h5A5A5A5A, 1'b0, 32'h0, StatusOk, CfgRowCount, 9'd0},
    '{StepItem, ModeRead, 8'd255, 8'd255, 32'hFFFFFFFF, 1'b0, 32'h0, StatusOk, CfgRowCount, 9'd0},
    '{StepItem, ModeAdd, 8'd1, 8'd7, 32'h1, 1'b0, 32'h0, StatusOk, CfgRowCount, 9'd0},
    '{StepItem, ModeAdd, 8'd0, 8'd5, 32'h80000000, 1'b0, 32'h0, StatusOk, CfgRowCount, 9'd0},
    '{StepItem, ModeAdd, 8'd128, 8'd128, 32'h12345678, 1'b0, 32'h0, StatusOk, CfgRowCount, 9'd0},
    '{StepItem, ModeRead, 8'd128, 8'd128, 32'h0, 1'b0, 32'h0, StatusOk, CfgRowCount, 9'd0},
    '{StepItem, ModeAdd, 8'd1, 8'd7, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF, StatusSat,
      CfgRowCount, 9'd0},
    '{StepItem, ModeRead, 8'd1, 8'd6, 32'h0, 1'b0, 32'h0, StatusOk, CfgRowCount, 9'd0},
    '{StepItem, ModeAdd, 8'd0, 8'd2, 32'h1, 1'b0, 32'h0, StatusOk, CfgRowCount, 9'd0},
    '{StepWrite, ModeRead, 8'd0, 8'd0, 32'h0, 1'b0, 32'h0, StatusOk, CfgRowCount, 9'd1},
    '{StepWrite, ModeRead, 8'd0, 8'd0, 32'h0, 1'b0, 32'h0, StatusOk, CfgColumnCount, 9'd1},
    '{StepItem, ModeRead, 8'd1, 8'd0, 32'h0, 1'b1, 32'h0, StatusRange, CfgRowCount, 9'd0},
    '{StepItem, ModeAdd, 8'd0, 8'd1, 32'h5, 1'b1, 32'h0, StatusRange, CfgRowCount, 9'd0},
    '{StepItem, ModeAdd, 8'd0, 8'd0, 32'h3, 1'b0, 32'h0, StatusOk, CfgRowCount, 9'd0},
    '{StepWrite, ModeRead, 8'd0, 8'd0, 32'h0, 1'b0, 32'h0, StatusOk, CfgRowCount, 9'd0},
    '{StepItem, ModeRead, 8'd0, 8'd0, 32'h0, 1'b1, 32'h0, StatusRange, CfgRowCount, 9'd0},
    '{StepWrite, ModeRead, 8'd0, 8'd0, 32'h0, 1'b0, 32'h0, StatusOk, CfgRowCount, 9'd511},
    '{StepWrite, ModeRead, 8'd0, 8'd0, 32'h0, 1'b0, 32'h0, StatusOk, CfgColumnCount, 9'd511},
    '{StepItem, ModeRead, 8'd255, 8'd255, 32'h0, 1'b0, 32'h0, StatusOk, CfgRowCount, 9'd0}
  };

  int phase_rows  [NumPhases] = '{256, 1, 0, 511, 64, 256, 200};
  int phase_cols  [NumPhases] = '{256, 1, 256, 511, 3, 0, 256};
  int phase_items [NumPhases] = '{500, 150, 40, 500, 300, 40, 470};

  csr_sparse_matrix_store_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .mode_i       (mode_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int usable_count(logic [CountW-1:0] setting);
    return (setting < MaxRows) ? int'(setting) : int'(MaxRows);
  endfunction

  function automatic bit locate_entry(int r, int c, output int pos);
    int last;
    int total;
    pos   = int'(row_start[r]);
    last  = int'(row_start[r+1]);
    total = int'(row_start[MaxRows]);
    if (last > total) begin
      last = total;
    end
    while (pos < last && int'(entry_column[pos]) < c) begin
      pos++;
    end
    return pos < last && int'(entry_column[pos]) == c;
  endfunction

  function automatic matrix_answer_t apply_matrix_op(logic mode, logic [IndexW-1:0] r,
                                                     logic [IndexW-1:0] c,
                                                     logic signed [ValueW-1:0] addend);
    matrix_answer_t answer;
    int pos;
    int total;
    int k;
    bit found;
    longint sum;
    answer.value  = '0;
    answer.status = StatusOk;
    if (int'(r) >= usable_count(rows_in_use) || int'(c) >= usable_count(columns_in_use)) begin
      answer.status = StatusRange;
    end else begin
      found = locate_entry(int'(r), int'(c), pos);
      total = int'(row_start[MaxRows]);
      if (mode == ModeRead || addend == 0) begin
        if (found) begin
          answer.value = entry_value[pos];
        end
      end else if (found) begin
        sum = longint'(entry_value[pos]) + longint'(addend);
        if (sum > ValueMax) begin
          sum = ValueMax;
          answer.status = StatusSat;
        end else if (sum < ValueMin) begin
          sum = ValueMin;
          answer.status = StatusSat;
        end
        entry_value[pos] = sum[31:0];
        answer.value = sum[31:0];
      end else if (total >= MaxEntries) begin
        answer.status = StatusFull;
      end else begin
        for (k = total; k > pos; k--) begin
          entry_column[k] = entry_column[k-1];
          entry_value[k]  = entry_value[k-1];
        end
        entry_column[pos] = c;
        entry_value[pos]  = addend;
        for (k = int'(r) + 1; k <= MaxRows; k++) begin
          row_start[k] = row_start[k] + 11'd1;
        end
        answer.value = addend;
      end
    end
    return answer;
  endfunction

  always @(posedge clk_i) begin : track
    matrix_answer_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        want = apply_matrix_op(mode_i, row_i, column_i, value_i);
        if (table_known) begin
          want.value  = table_value;
          want.status = table_status;
        end
        pending_answers = {pending_answers, want};
      end
      if (done_o) begin
        if (pending_answers.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, read_value %h status %0d", $time,
                   read_value_o, status_o);
        end else begin
          want = pending_answers.pop_front();
          if (read_value_o !== want.value) begin
            mismatch_count++;
            $display("%0t: read_value expected %h, actual %h", $time, want.value,
                     read_value_o);
          end
          if (status_o !== want.status) begin
            mismatch_count++;
            $display("%0t: status expected %0d, actual %0d", $time, want.status, status_o);
          end
        end
      end
    end
  end

  function automatic int idle_cycles(bit quiet);
    int k;
    k = $urandom_range(0, 99);
    if (quiet || k < 55) begin
      return 0;
    end else if (k < 85) begin
      return $urandom_range(1, 3);
    end else if (k < 97) begin
      return $urandom_range(4, 20);
    end
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [IndexW-1:0] pick_index(int limit);
    int k;
    k = $urandom_range(0, 99);
    if (limit == 0 || k < 15) begin
      return 8'($urandom_range(0, 255));
    end else if (k < 60) begin
      return 8'($urandom_range(0, ((limit < 6) ? limit : 6) - 1));
    end
    return 8'($urandom_range(0, limit - 1));
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'h7FFFFFFF;
      2: return 32'h80000000;
      3: return 32'($urandom_range(1, 255));
      4: return -32'($urandom_range(1, 255));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic mode, logic [IndexW-1:0] r, logic [IndexW-1:0] c,
                           logic [ValueW-1:0] v, logic known, logic [ValueW-1:0] want_value,
                           status_e want_status, int gap);
    start_i      <= 1'b1;
    mode_i       <= mode;
    row_i        <= r;
    column_i     <= c;
    value_i      <= v;
    table_known  <= known;
    table_value  <= want_value;
    table_status <= want_status;
    @(posedge clk_i);
    while (busy_o) begin
      @(posedge clk_i);
    end
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0 || busy_o) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_register(cfg_index_e index, logic [CountW-1:0] data);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    if (index == CfgRowCount) begin
      rows_in_use = data;
    end else begin
      columns_in_use = data;
    end
  endtask

  task automatic run_random(int count);
    int i;
    bit quiet;
    quiet = 1'b0;
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 199) == 0) begin
        drain_results();
      end
      send_item(($urandom_range(0, 99) < 35) ? ModeRead : ModeAdd,
                pick_index(usable_count(rows_in_use)),
                pick_index(usable_count(columns_in_use)),
                pick_value(), 1'b0, 32'h0, StatusOk, idle_cycles(quiet));
    end
  endtask

  initial begin : stimulus
    int fill_row;
    int fill_col;
    int pos;
    foreach (row_start[i]) begin
      row_start[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == StepWrite) begin
        write_register(plan[i].reg_index, plan[i].reg_data);
      end else begin
        send_item(plan[i].mode, plan[i].row, plan[i].column, plan[i].value, plan[i].known,
                  plan[i].want_value, plan[i].want_status, idle_cycles(1'b0));
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      write_register(CfgRowCount, 9'(phase_rows[p]));
      write_register(CfgColumnCount, 9'(phase_cols[p]));
      run_random(phase_items[p]);
    end

    // Fill from the bottom right corner so that each insert updates few row offsets.
    write_register(CfgRowCount, 9'd256);
    write_register(CfgColumnCount, 9'd256);
    fill_row = 255;
    fill_col = 255;
    while (row_start[MaxRows] < MaxEntries) begin
      if (!locate_entry(fill_row, fill_col, pos)) begin
        send_item(ModeAdd, 8'(fill_row), 8'(fill_col), $urandom | 32'h1, 1'b0, 32'h0,
                  StatusOk, 0);
        drain_results();
      end
      if (fill_col == 0) begin
        fill_col = 255;
        fill_row--;
      end else begin
        fill_col--;
      end
    end
    run_random(60);

    drain_results();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
